@@ sv/brbf_pkg.sv @@
// shared types and constants for the byte ring buffer fifo
package brbf_pkg;

  localparam int DataW = 8;
  localparam int PtrW  = 8;
  localparam int CntW  = 8;
  localparam int CapW  = 9;
  localparam int CmdW  = 2;
  localparam int ApbW  = 32;
  localparam int AddrW = 2;

  localparam logic [CapW-1:0] CapMax   = 9'd256;
  localparam logic [CapW-1:0] CapMin   = 9'd2;
  localparam logic [AddrW-1:0] RegCap  = 2'd0;

  typedef enum logic [CmdW-1:0] {
    CmdPush  = 2'd0,
    CmdPop   = 2'd1,
    CmdPeek  = 2'd2,
    CmdClear = 2'd3
  } cmd_e;

endpackage

@@ sv/byte_ring_buffer_fifo_top.sv @@
// byte ring buffer fifo with push, pop, peek and clear over one synchronous memory
//
// channel   | direction | tdata                                   | tuser
// s_axis    | in        | data_in[7:0]                            | cmd[1:0]
// m_axis    | out       | data_out[7:0] fill_count[15:8] free[23:16] | ok[0]
// apb       | in        | capacity_in_use at address 0, bits 8:0  | -
//
// one request per cycle unless the output stalls; a taken request's result is registered
// in stage s1 and then in the output register, with the memory read held in rd_data_q
// pointers and the fill count are updated when the request is taken
// reset sets capacity to the smaller of DEPTH and 256 and empties the ring
// a stalled output holds its result while one more request waits behind it
module byte_ring_buffer_fifo_top #(
  parameter int DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [brbf_pkg::DataW-1:0]    s_axis_tdata,   // data_in
  input  logic [brbf_pkg::CmdW-1:0]     s_axis_tuser,   // cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [3*brbf_pkg::DataW-1:0]  m_axis_tdata,   // data_out, fill_count, free_space
  output logic                          m_axis_tuser,   // ok
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brbf_pkg::AddrW-1:0]    paddr,
  input  logic [brbf_pkg::ApbW-1:0]     pwdata,
  output logic [brbf_pkg::ApbW-1:0]     prdata,
  output logic                          pready
);
  import brbf_pkg::*;

  localparam int MemAw = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CapTopI = (DEPTH < 256) ? DEPTH : 256;
  localparam logic [CapW-1:0] CapTop = CapW'(CapTopI);

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rd_data_q;

  logic [CapW-1:0] cap_q, cap_d;
  logic [PtrW-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            s1_valid_q;
  logic            s1_ok_q, s1_ok_d;
  logic            s1_rd_q, s1_rd_d;
  logic [CntW-1:0] s1_fill_q;
  logic [CntW-1:0] s1_free_q, s1_free_d;

  logic             out_valid_q;
  logic             out_ok_q;
  logic [DataW-1:0] out_data_q;
  logic [CntW-1:0]  out_fill_q;
  logic [CntW-1:0]  out_free_q;

  logic            s1_move, in_acc, cfg_wr;
  logic            full, empty;
  logic [CapW-1:0] wnext, rnext, cap_wr, free_w;
  cmd_e            cmd;
  logic            mem_we, mem_re;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr == RegCap);
  assign prdata  = (paddr == RegCap) ? ApbW'(cap_q) : '0;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);

  assign full  = ({1'b0, cnt_q} == (cap_q - CapW'(1)));
  assign empty = (cnt_q == '0);
  assign wnext = (({1'b0, wptr_q} + CapW'(1)) >= cap_q) ? '0 : ({1'b0, wptr_q} + CapW'(1));
  assign rnext = (({1'b0, rptr_q} + CapW'(1)) >= cap_q) ? '0 : ({1'b0, rptr_q} + CapW'(1));

  always_comb begin
    cap_wr = pwdata[CapW-1:0];
    if (cap_wr < CapMin) begin
      cap_wr = CapMin;
    end else if (cap_wr > CapTop) begin
      cap_wr = CapTop;
    end
  end

  always_comb begin
    cap_d   = cap_q;
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    cnt_d   = cnt_q;
    s1_ok_d = 1'b0;
    s1_rd_d = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    if (cfg_wr) begin
      cap_d  = cap_wr;
      rptr_d = '0;
      wptr_d = '0;
      cnt_d  = '0;
    end else if (in_acc) begin
      unique case (cmd)
        CmdPush: begin
          if (!full) begin
            mem_we  = 1'b1;
            wptr_d  = wnext[PtrW-1:0];
            cnt_d   = cnt_q + CntW'(1);
            s1_ok_d = 1'b1;
          end
        end
        CmdPop: begin
          if (!empty) begin
            mem_re  = 1'b1;
            s1_rd_d = 1'b1;
            rptr_d  = rnext[PtrW-1:0];
            cnt_d   = cnt_q - CntW'(1);
            s1_ok_d = 1'b1;
          end
        end
        CmdPeek: begin
          if (!empty) begin
            mem_re  = 1'b1;
            s1_rd_d = 1'b1;
            s1_ok_d = 1'b1;
          end
        end
        CmdClear: begin
          rptr_d  = '0;
          wptr_d  = '0;
          cnt_d   = '0;
          s1_ok_d = 1'b1;
        end
        default: begin
          s1_ok_d = 1'b0;
        end
      endcase
    end
  end

  assign free_w    = cap_q - CapW'(1) - {1'b0, cnt_d};
  assign s1_free_d = free_w[CntW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[MemAw'(wptr_q)] <= s_axis_tdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[MemAw'(rptr_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapTop;
      rptr_q      <= '0;
      wptr_q      <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      cnt_q  <= cnt_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ok_q   <= s1_ok_d;
      s1_rd_q   <= s1_rd_d;
      s1_fill_q <= cnt_d;
      s1_free_q <= s1_free_d;
    end
    if (s1_move) begin
      out_ok_q   <= s1_ok_q;
      out_data_q <= s1_rd_q ? rd_data_q : '0;
      out_fill_q <= s1_fill_q;
      out_free_q <= s1_free_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_free_q, out_fill_q, out_data_q};
  assign m_axis_tuser  = out_ok_q;

endmodule
